@@ rtl/dtfv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfv_pkg: shared types and constants of the date/time field validator
// Field widths, position and character codes, limits, and the beat and
// record types passed between the front scanner, the queue and the checker.
// ----------------------------------------------------------------------------
package dtfv_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned DayW   = 7;
  localparam int unsigned MonW   = 7;
  localparam int unsigned YearW  = 14;
  localparam int unsigned HourW  = 7;
  localparam int unsigned MinW   = 7;
  localparam int unsigned PosW   = 5;
  localparam int unsigned Mod25W = 5;

  localparam int unsigned QueueDepthDefault = 2;

  // character positions inside dd-mm-yyyy hh:mm
  localparam logic [PosW-1:0] PosDayEnd   = 5'd2;
  localparam logic [PosW-1:0] PosDash1    = 5'd2;
  localparam logic [PosW-1:0] PosMonEnd   = 5'd5;
  localparam logic [PosW-1:0] PosDash2    = 5'd5;
  localparam logic [PosW-1:0] PosYearEnd  = 5'd10;
  localparam logic [PosW-1:0] PosSpace    = 5'd10;
  localparam logic [PosW-1:0] PosHourEnd  = 5'd13;
  localparam logic [PosW-1:0] PosColon    = 5'd13;
  localparam logic [PosW-1:0] FieldLen    = 5'd16;
  localparam logic [PosW-1:0] PosSat      = 5'd17;

  localparam logic [CharW-1:0] ChDash  = 8'h2D;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChColon = 8'h3A;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;

  localparam logic [YearW-1:0] YearMin   = 14'd1900;
  localparam logic [MonW-1:0]  MonthMax  = 7'd12;
  localparam logic [HourW-1:0] HourMax   = 7'd23;
  localparam logic [MinW-1:0]  MinuteMax = 7'd59;

  localparam logic [MonW-1:0] MonFeb = 7'd2;
  localparam logic [MonW-1:0] MonApr = 7'd4;
  localparam logic [MonW-1:0] MonJun = 7'd6;
  localparam logic [MonW-1:0] MonSep = 7'd9;
  localparam logic [MonW-1:0] MonNov = 7'd11;

  localparam logic [DayW-1:0] Days31 = 7'd31;
  localparam logic [DayW-1:0] Days30 = 7'd30;
  localparam logic [DayW-1:0] Days29 = 7'd29;
  localparam logic [DayW-1:0] Days28 = 7'd28;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             final_char;
  } in_item_t;

  typedef struct packed {
    logic             is_valid;
    logic [DayW-1:0]  day_value;
    logic [MonW-1:0]  month_value;
    logic [YearW-1:0] year_value;
    logic [HourW-1:0] hour_value;
    logic [MinW-1:0]  minute_value;
  } out_item_t;

  // one finished field, handed from the scanner to the checker
  typedef struct packed {
    logic             fmt_ok;
    logic             leap;
    logic [DayW-1:0]  day;
    logic [MonW-1:0]  month;
    logic [YearW-1:0] year;
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
  } rec_t;

endpackage

@@ rtl/dtfv_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfv_stream_if: valid/ready stream channel
// Carries one payload beat per cycle when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dtfv_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/dtfv_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfv_scanner: front end of the validator
// Takes one character per beat, checks it against its position, builds the
// decimal fields and pushes one record into the queue on the final character.
// ----------------------------------------------------------------------------
module dtfv_scanner (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  dtfv_pkg::in_item_t item_i,
  output logic             push_o,
  output dtfv_pkg::rec_t   rec_o
);
  import dtfv_pkg::*;

  logic [PosW-1:0]   pos_q, pos_d, pos_inc;
  logic              bad_q, bad_d, char_bad, is_digit, take_digit;
  logic [DayW-1:0]   day_q, day_d;
  logic [MonW-1:0]   mon_q, mon_d;
  logic [YearW-1:0]  year_q, year_d;
  logic [HourW-1:0]  hour_q, hour_d;
  logic [MinW-1:0]   min_q, min_d;
  logic [Mod25W-1:0] m25_q, m25_d;
  logic [3:0]        digit;

  function automatic logic [6:0] acc7(logic [6:0] a, logic [3:0] d);
    logic [10:0] t;
    t = 11'(a) * 11'd10 + 11'(d);
    return t[6:0];
  endfunction

  function automatic logic [13:0] acc14(logic [13:0] a, logic [3:0] d);
    logic [17:0] t;
    t = 18'(a) * 18'd10 + 18'(d);
    return t[13:0];
  endfunction

  // running year mod 25; x stays below 250, so x*164>>12 is the exact quotient
  function automatic logic [4:0] mod25_step(logic [4:0] r, logic [3:0] d);
    logic [7:0]  x;
    logic [15:0] p;
    logic [7:0]  qm;
    x  = 8'(r) * 8'd10 + 8'(d);
    p  = 16'(x) * 16'd164;
    qm = 8'(p[15:12]) * 8'd25;
    return 5'(x - qm);
  endfunction

  assign is_digit = (item_i.char_code >= ChZero) && (item_i.char_code <= ChNine);
  assign digit    = item_i.char_code[3:0];
  assign pos_inc  = (pos_q < PosSat) ? pos_q + 5'd1 : pos_q;

  always_comb begin
    char_bad   = 1'b0;
    take_digit = 1'b0;
    if (pos_q >= FieldLen) begin
      char_bad = 1'b1;
    end else if (pos_q inside {PosDash1, PosDash2}) begin
      char_bad = (item_i.char_code != ChDash);
    end else if (pos_q == PosSpace) begin
      char_bad = (item_i.char_code != ChSpace);
    end else if (pos_q == PosColon) begin
      char_bad = (item_i.char_code != ChColon);
    end else begin
      char_bad   = !is_digit;
      take_digit = is_digit;
    end
  end

  always_comb begin
    pos_d  = pos_q;
    bad_d  = bad_q;
    day_d  = day_q;
    mon_d  = mon_q;
    year_d = year_q;
    hour_d = hour_q;
    min_d  = min_q;
    m25_d  = m25_q;
    if (fire_i) begin
      pos_d = pos_inc;
      bad_d = bad_q | char_bad;
      if (take_digit) begin
        if (pos_q < PosDayEnd) begin
          day_d = acc7(day_q, digit);
        end else if (pos_q < PosMonEnd) begin
          mon_d = acc7(mon_q, digit);
        end else if (pos_q < PosYearEnd) begin
          year_d = acc14(year_q, digit);
          m25_d  = mod25_step(m25_q, digit);
        end else if (pos_q < PosHourEnd) begin
          hour_d = acc7(hour_q, digit);
        end else begin
          min_d = acc7(min_q, digit);
        end
      end
    end
  end

  // record built from the values this character leaves behind
  always_comb begin
    push_o        = fire_i && item_i.final_char;
    rec_o.fmt_ok  = !bad_d && (pos_d == FieldLen);
    // leap: divisible by 4 and not by 100, or by 400 (= by 16 and by 25)
    rec_o.leap    = (year_d[1:0] == 2'd0) && ((m25_d != 5'd0) || (year_d[3:0] == 4'd0));
    rec_o.day     = day_d;
    rec_o.month   = mon_d;
    rec_o.year    = year_d;
    rec_o.hour    = hour_d;
    rec_o.minute  = min_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      bad_q  <= 1'b0;
      day_q  <= '0;
      mon_q  <= '0;
      year_q <= '0;
      hour_q <= '0;
      min_q  <= '0;
      m25_q  <= '0;
    end else if (push_o) begin
      pos_q  <= '0;
      bad_q  <= 1'b0;
      day_q  <= '0;
      mon_q  <= '0;
      year_q <= '0;
      hour_q <= '0;
      min_q  <= '0;
      m25_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      bad_q  <= bad_d;
      day_q  <= day_d;
      mon_q  <= mon_d;
      year_q <= year_d;
      hour_q <= hour_d;
      min_q  <= min_d;
      m25_q  <= m25_d;
    end
  end

endmodule

@@ rtl/dtfv_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfv_queue: record queue between scanner and checker
// Small circular buffer; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module dtfv_queue #(
  parameter int unsigned Depth = dtfv_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dtfv_pkg::rec_t rec_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           avail_o,
  output dtfv_pkg::rec_t head_o
);
  import dtfv_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  rec_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntFull);
  assign avail_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

@@ rtl/dtfv_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfv_checker: back end of the validator
// Applies the calendar and clock range checks to the queue head and holds
// the result beat in an output register until it is taken.
// ----------------------------------------------------------------------------
module dtfv_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           avail_i,
  input  dtfv_pkg::rec_t head_i,
  output logic           pop_o,
  dtfv_stream_if.source  out_o
);
  import dtfv_pkg::*;

  logic            out_valid_q;
  out_item_t       out_q, res;
  logic [DayW-1:0] mlen;
  logic            ok;

  always_comb begin
    case (head_i.month)
      MonApr, MonJun, MonSep, MonNov: mlen = Days30;
      MonFeb:                         mlen = head_i.leap ? Days29 : Days28;
      default:                        mlen = Days31;
    endcase
  end

  always_comb begin
    ok = head_i.fmt_ok
         && (head_i.month != '0) && (head_i.month <= MonthMax)
         && (head_i.year >= YearMin)
         && (head_i.hour <= HourMax) && (head_i.minute <= MinuteMax)
         && (head_i.day != '0) && (head_i.day <= mlen);
    res.is_valid     = ok;
    res.day_value    = ok ? head_i.day    : '0;
    res.month_value  = ok ? head_i.month  : '0;
    res.year_value   = ok ? head_i.year   : '0;
    res.hour_value   = ok ? head_i.hour   : '0;
    res.minute_value = ok ? head_i.minute : '0;
  end

  assign pop_o = avail_i && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

@@ rtl/date_time_field_validator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_time_field_validator: dd-mm-yyyy hh:mm text field checker
// Streams characters in, one beat each, and emits one verdict per field.
// ----------------------------------------------------------------------------
// The block takes one character per clock on in_i (final_char marks the last
// one of a field) and returns one beat on out_o for every final character.
// A field passes only if it is exactly 16 characters of the form
// dd-mm-yyyy hh:mm, month is 1..12, year is 1900 or later, hour is 0..23,
// minute is 0..59 and day fits the month (Gregorian leap years give February
// 29 days). When is_valid is low all value fields read zero. Sustained rate
// is one character per cycle, set by the scanner which does one position
// check and one decimal shift-add per beat. The verdict reaches out_o through
// the queue and the checker's output register. Finished fields wait in a queue
// of QueueDepth entries in front of the checker; the input stalls only when
// that queue is full, i.e. when results are held back for longer than the
// queue can absorb. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module date_time_field_validator #(
  parameter int unsigned QueueDepth = dtfv_pkg::QueueDepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dtfv_stream_if.sink  in_i,
  dtfv_stream_if.source out_o
);
  import dtfv_pkg::*;

  logic  push, pop, q_full, q_avail, in_fire;
  rec_t  push_rec, head_rec;

  // input is held off only while the record queue has no room
  assign in_i.ready = !q_full;
  assign in_fire    = in_i.valid && in_i.ready;

  // front: position check and decimal accumulation
  dtfv_scanner u_scanner (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .item_i (in_i.payload),
    .push_o (push),
    .rec_o  (push_rec)
  );

  // decouples the front from a stalled output
  dtfv_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .pop_i   (pop),
    .full_o  (q_full),
    .avail_o (q_avail),
    .head_o  (head_rec)
  );

  // back: calendar checks and output register
  dtfv_checker u_checker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (q_avail),
    .head_i  (head_rec),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

@@ rtl/dtfv_port_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfv_port_checker: port-level assertions for the validator
// Watches the result channel and checks handshake and result consistency.
// ----------------------------------------------------------------------------
module dtfv_port_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input dtfv_pkg::out_item_t out_item_i
);
  import dtfv_pkg::*;

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_item_i))
    else $error("result beat changed while stalled");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_item_i.is_valid |->
      (out_item_i.day_value == '0) && (out_item_i.month_value == '0) &&
      (out_item_i.year_value == '0) && (out_item_i.hour_value == '0) &&
      (out_item_i.minute_value == '0))
    else $error("rejected field carries nonzero values");

  a_accept_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.is_valid |->
      (out_item_i.month_value != '0) && (out_item_i.month_value <= MonthMax) &&
      (out_item_i.year_value >= YearMin) && (out_item_i.hour_value <= HourMax) &&
      (out_item_i.minute_value <= MinuteMax) && (out_item_i.day_value != '0) &&
      (out_item_i.day_value <= Days31))
    else $error("accepted field out of range");

endmodule

bind date_time_field_validator dtfv_port_checker u_dtfv_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.payload)
);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: date/time field validator stream check
// Feeds character beats of dd-mm-yyyy hh:mm text fields into the validator,
// predicts the verdict of every field in the bench, and compares each output
// beat field by field against the oldest pending verdict. Runs directed
// calendar corner cases, a long output back-pressure burst, then random
// fields under four idle/stall mixes on both stream sides.
// ----------------------------------------------------------------------------
module testbench;
  import dtfv_pkg::*;

  typedef logic [CharW-1:0] char_t;
  typedef char_t text_t[$];

  localparam int unsigned WatchdogLimit = 3000;  // cycles with no beat on either side
  localparam int unsigned LongHold      = 400;   // long output hold-off, in cycles
  localparam int unsigned PhaseChars    = 80;    // random characters per idle mix

  logic clk;
  logic rst_n;

  dtfv_stream_if #(.payload_t(in_item_t))  in_ch ();
  dtfv_stream_if #(.payload_t(out_item_t)) out_ch ();

  date_time_field_validator dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // character beats still to be offered, and verdicts still to come back
  in_item_t  char_q[$];
  out_item_t verdict_q[$];

  int unsigned send_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned rx_hold_left;
  int unsigned chars_queued;
  int unsigned fail_cnt;
  int unsigned quiet_cycles;
  out_item_t   want;

  // Bench copy of the scanner state. Reset value is all zero, and it returns
  // there after every final character.
  logic [PosW-1:0]  scan_pos;
  logic             scan_bad;
  logic [DayW-1:0]  day_acc;
  logic [MonW-1:0]  mon_acc;
  logic [YearW-1:0] year_acc;
  logic [HourW-1:0] hour_acc;
  logic [MinW-1:0]  min_acc;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Gregorian month length; months outside 1..12 fall to 31, the caller
  // rejects them anyway.
  function automatic int unsigned days_of_month(int unsigned m, int unsigned y);
    logic leap;
    if (m == MonApr || m == MonJun || m == MonSep || m == MonNov) return Days30;
    if (m != MonFeb) return Days31;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    return leap ? Days29 : Days28;
  endfunction

  function automatic void clear_scan();
    scan_pos = '0;
    scan_bad = 1'b0;
    day_acc  = '0;
    mon_acc  = '0;
    year_acc = '0;
    hour_acc = '0;
    min_acc  = '0;
  endfunction

  // Advance the bench scanner by one accepted beat; on the final character
  // push the verdict the block must return.
  function automatic void scan_char(in_item_t it);
    char_t       c;
    logic [3:0]  d;
    logic        ok;
    out_item_t   v;
    c = it.char_code;
    if (scan_pos >= FieldLen) begin
      scan_bad = 1'b1;                          // field ran past 16 characters
    end else if (scan_pos == PosDash1 || scan_pos == PosDash2) begin
      if (c != ChDash) scan_bad = 1'b1;
    end else if (scan_pos == PosSpace) begin
      if (c != ChSpace) scan_bad = 1'b1;
    end else if (scan_pos == PosColon) begin
      if (c != ChColon) scan_bad = 1'b1;
    end else if (c < ChZero || c > ChNine) begin
      scan_bad = 1'b1;                          // accumulators keep their value
    end else begin
      d = 4'(c - ChZero);
      if (scan_pos < PosDayEnd)       day_acc  = DayW'(day_acc * 10 + d);
      else if (scan_pos < PosMonEnd)  mon_acc  = MonW'(mon_acc * 10 + d);
      else if (scan_pos < PosYearEnd) year_acc = YearW'(year_acc * 10 + d);
      else if (scan_pos < PosHourEnd) hour_acc = HourW'(hour_acc * 10 + d);
      else                            min_acc  = MinW'(min_acc * 10 + d);
    end
    if (scan_pos < PosSat) scan_pos = scan_pos + 1'b1;
    if (!it.final_char) return;

    ok = !scan_bad && scan_pos == FieldLen
      && mon_acc >= 1 && mon_acc <= MonthMax && year_acc >= YearMin
      && hour_acc <= HourMax && min_acc <= MinuteMax
      && day_acc >= 1 && day_acc <= days_of_month(mon_acc, year_acc);
    v = '0;
    if (ok) begin
      v.is_valid     = 1'b1;
      v.day_value    = day_acc;
      v.month_value  = mon_acc;
      v.year_value   = year_acc;
      v.hour_value   = hour_acc;
      v.minute_value = min_acc;
    end
    verdict_q.push_back(v);
    clear_scan();
  endfunction

  function automatic text_t to_chars(string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  // Queue one field; the last character carries the final mark.
  function automatic void queue_text(text_t t);
    in_item_t it;
    foreach (t[i]) begin
      it.char_code  = t[i];
      it.final_char = (i == t.size() - 1);
      char_q.push_back(it);
    end
    chars_queued += t.size();
  endfunction

  // One random field. Most are well formed with values near the calendar
  // limits; the rest are corrupted, cut short, overlong or pure noise.
  function automatic void queue_random_field();
    int unsigned d, m, y, h, mi, kind, n;
    text_t t;
    m  = $urandom_range(13);
    case ($urandom_range(7))
      0: y = 1899;
      1: y = 1900;
      2: y = 2000;
      3: y = 2100;
      4: y = 2400;
      5: y = $urandom_range(9999);
      default: y = $urandom_range(2099, 1900);
    endcase
    if ($urandom_range(3) == 0) d = days_of_month(m, y) + $urandom_range(1);
    else d = $urandom_range(31);
    h  = $urandom_range(25);
    mi = $urandom_range(61);
    t  = to_chars($sformatf("%02d-%02d-%04d %02d:%02d", d, m, y, h, mi));
    kind = $urandom_range(99);
    if (kind < 60) begin
      // well formed as is
    end else if (kind < 75) begin
      t[$urandom_range(15)] = char_t'($urandom_range(255));
    end else if (kind < 85) begin
      n = $urandom_range(15, 1);
      t = t[0:n-1];
    end else if (kind < 93) begin
      n = $urandom_range(24, 1);
      repeat (n) t.push_back(char_t'($urandom_range(255)));
    end else begin
      t = {};
      n = $urandom_range(20, 1);
      repeat (n) t.push_back(char_t'($urandom_range(255)));
    end
    queue_text(t);
  endfunction

  // Sender: offer the next beat whenever the slot is free. A beat counts as
  // taken at the edge where valid and ready are both high; valid stays up
  // without a drop when the next beat follows straight on.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.payload <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) scan_char(in_ch.payload);
      if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid   <= 1'b1;
        in_ch.payload <= char_q.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: check every verdict beat, then pick ready for the next edge.
  // A pending long hold-off overrides the random stall.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          $error("verdict beat with none pending: %p", out_ch.payload);
          fail_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (out_ch.payload.is_valid !== want.is_valid) begin
            $error("is_valid: expected %0d, got %0d", want.is_valid,
                   out_ch.payload.is_valid);
            fail_cnt++;
          end
          if (out_ch.payload.day_value !== want.day_value) begin
            $error("day_value: expected %0d, got %0d", want.day_value,
                   out_ch.payload.day_value);
            fail_cnt++;
          end
          if (out_ch.payload.month_value !== want.month_value) begin
            $error("month_value: expected %0d, got %0d", want.month_value,
                   out_ch.payload.month_value);
            fail_cnt++;
          end
          if (out_ch.payload.year_value !== want.year_value) begin
            $error("year_value: expected %0d, got %0d", want.year_value,
                   out_ch.payload.year_value);
            fail_cnt++;
          end
          if (out_ch.payload.hour_value !== want.hour_value) begin
            $error("hour_value: expected %0d, got %0d", want.hour_value,
                   out_ch.payload.hour_value);
            fail_cnt++;
          end
          if (out_ch.payload.minute_value !== want.minute_value) begin
            $error("minute_value: expected %0d, got %0d", want.minute_value,
                   out_ch.payload.minute_value);
            fail_cnt++;
          end
        end
      end
      if (rx_hold_left != 0) begin
        rx_hold_left <= rx_hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog: any beat on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Wait until every queued beat went in and every verdict came back.
  // Sampled at the falling edge so the sender's updates have settled.
  task automatic drain();
    do @(negedge clk);
    while (char_q.size() != 0 || in_ch.valid || verdict_q.size() != 0);
  endtask

  initial begin
    text_t t;
    int unsigned start;
    rst_n         = 1'b0;
    clk           = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    rx_hold_left  = 0;
    chars_queued  = 0;
    fail_cnt      = 0;
    quiet_cycles  = 0;
    clear_scan();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed fields, no idling: leap rules, month lengths, limits of every
    // value, bad separators, short and long fields, zero and all-ones bytes.
    queue_text(to_chars("29-02-2000 23:59"));   // divisible by 400: leap
    queue_text(to_chars("29-02-1900 00:00"));   // divisible by 100: not leap
    queue_text(to_chars("29-02-2024 12:30"));
    queue_text(to_chars("29-02-2023 12:30"));
    queue_text(to_chars("31-04-2020 10:10"));   // 30-day month overrun
    queue_text(to_chars("30-11-2020 10:10"));
    queue_text(to_chars("31-12-9999 23:59"));   // top of every field
    queue_text(to_chars("01-01-1900 00:00"));   // bottom of every field
    queue_text(to_chars("00-01-2000 00:00"));   // day zero
    queue_text(to_chars("15-13-2000 08:00"));
    queue_text(to_chars("15-00-2000 08:00"));
    queue_text(to_chars("15-06-1899 08:00"));
    queue_text(to_chars("15-06-2000 24:00"));
    queue_text(to_chars("15-06-2000 23:60"));
    queue_text(to_chars("15/06-2000 12:00"));   // wrong separators
    queue_text(to_chars("15-06-2000T12-00"));
    queue_text(to_chars("15-06-2000"));         // final mark too early
    queue_text(to_chars("15-06-2000 12:0005")); // runs past 16
    t = to_chars("15-06-2000 12:00");
    t[3] = 8'h00;                               // zero byte does not end a field
    queue_text(t);
    t = to_chars("15-06-2000 12:00");
    t[7] = 8'hFF;
    queue_text(t);
    t = {8'hFF};
    queue_text(t);                              // one-character field
    drain();

    // Hold the output off for a long stretch while random fields keep coming,
    // so the record queue fills and the input has to stall.
    rx_hold_left = LongHold;
    repeat (10) queue_random_field();
    drain();

    // Random fields under each idle mix; the sender waits for all verdicts
    // before the next mix starts.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin send_idle_pct = 80; rx_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rx_stall_pct = 80; end
        default: begin send_idle_pct = 24; rx_stall_pct = 24; end
      endcase
      start = chars_queued;
      while (chars_queued - start < PhaseChars) queue_random_field();
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/dtfv_pkg.sv
rtl/dtfv_stream_if.sv
rtl/dtfv_scanner.sv
rtl/dtfv_queue.sv
rtl/dtfv_checker.sv
rtl/date_time_field_validator.sv
rtl/dtfv_port_checker.sv
verif/testbench.sv
